// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the lock rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is skipped while reset is high
`define KCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that also holds during reset
`define KCL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/kcl_pkg.sv =====
// shared types and constants of the keypad code lock
// no dependencies; used by kcl_key_if, kcl_res_if, kcl_core, keypad_code_lock and the testbench
package kcl_pkg;

  localparam int CODE_LENGTH = 6;
  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  localparam logic [3:0] MAX_DIGIT      = 4'd9;
  localparam logic [3:0] MAX_FAIL_RESET = 4'd3;

  typedef enum logic [2:0] {
    FN_DIGIT   = 3'd0,
    FN_CONFIRM = 3'd1,
    FN_CANCEL  = 3'd2,
    FN_CLOSE   = 3'd3,
    FN_MENU    = 3'd4,
    FN_CHANGE  = 3'd5,
    FN_MATCH   = 3'd6,
    FN_MISS    = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    ST_NONE        = 4'd0,
    ST_DIGIT       = 4'd1,
    ST_IGNORED     = 4'd2,
    ST_FORMAT_ERR  = 4'd3,
    ST_CODE_SET    = 4'd4,
    ST_CORRECT     = 4'd5,
    ST_WRONG       = 4'd6,
    ST_CANCELLED   = 4'd7,
    ST_CLOSED      = 4'd8,
    ST_MENU        = 4'd9,
    ST_FINGER_OPEN = 4'd10,
    ST_FINGER_MISS = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    MD_IDLE   = 2'd0,
    MD_READ   = 2'd1,
    MD_CHANGE = 2'd2
  } mode_t;

  typedef struct packed {
    func_t      func;
    logic [3:0] digit;
  } key_t;

  typedef struct packed {
    status_t    status;
    logic       door_open;
    logic       alarm;
    mode_t      entry_mode;
    logic [2:0] entered_count;
    logic       first_use_flag;
  } lock_res_t;

endpackage

// ===== hw/rtl/kcl_key_if.sv =====
// key and sensor request channel of the lock
// depends on kcl_pkg
interface kcl_key_if
  import kcl_pkg::*;
;
  logic       valid;
  logic       ready;
  func_t      func;
  logic [3:0] digit;

  modport source (output valid, output func, output digit, input ready);
  modport sink   (input valid, input func, input digit, output ready);
endinterface

// ===== hw/rtl/kcl_res_if.sv =====
// result channel of the lock
// depends on kcl_pkg
interface kcl_res_if
  import kcl_pkg::*;
;
  logic       valid;
  logic       ready;
  status_t    status;
  logic       door_open;
  logic       alarm;
  mode_t      entry_mode;
  logic [2:0] entered_count;
  logic       first_use_flag;

  modport source (output valid, output status, output door_open, output alarm,
                  output entry_mode, output entered_count, output first_use_flag,
                  input ready);
  modport sink   (input valid, input status, input door_open, input alarm,
                  input entry_mode, input entered_count, input first_use_flag,
                  output ready);
endinterface

// ===== hw/rtl/kcl_cfg_if.sv =====
// configuration write channel of the lock (max_fail)
// depends on nothing
interface kcl_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/keypad_code_lock.sv =====
// keypad code lock top level: request/result channels, input and result registers
// depends on kcl_pkg, kcl_key_if, kcl_res_if, kcl_cfg_if, kcl_core, assert_macros.svh
//
// usage
// - key: one request per key or sensor event (func, digit), valid/ready
// - res: exactly one result per request, in request order, valid/ready
// - cfg: writes max_fail; always ready, write only while no request is in flight
// an accepted request waits in the input register, then its result is held in the result register
// throughput: one request per cycle while the receiver takes results; the state update is a
//   single combinational step between the input register and the result register
// a pending result blocks the input register only while res.ready is low: the step runs
//   whenever the result register is empty or is being drained in the same cycle
// receiver stall: result register holds, input register fills, then key.ready
//   drops; nothing is lost or repeated
// reset (synchronous, rst high): both registers empty, door closed, no code
//   set (all zero digits), change entry open for first use, max_fail = 3
`include "assert_macros.svh"

module keypad_code_lock
  import kcl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  kcl_key_if.sink   key,
  kcl_res_if.source res,
  kcl_cfg_if.sink   cfg
);

  // input register
  key_t      key_q;
  logic      key_q_valid;

  // result register
  lock_res_t res_q;
  logic      res_valid;

  logic      [3:0] max_fail;
  logic      advance;
  logic      key_take;
  lock_res_t step_res;

  // step the lock whenever the result register can take the outcome
  assign advance  = key_q_valid && (!res_valid || res.ready);
  assign key.ready = !key_q_valid || advance;
  assign key_take = key.valid && key.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_q_valid <= 1'b0;
      res_valid   <= 1'b0;
      max_fail    <= MAX_FAIL_RESET;
    end else begin
      if (key.ready) key_q_valid <= key.valid;
      if (advance) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) max_fail <= cfg.data;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (key_take) begin
      key_q.func  <= key.func;
      key_q.digit <= key.digit;
    end
    if (advance) res_q <= step_res;
  end

  kcl_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .key      (key_q),
    .max_fail (max_fail),
    .res      (step_res)
  );

  assign res.valid          = res_valid;
  assign res.status         = res_q.status;
  assign res.door_open      = res_q.door_open;
  assign res.alarm          = res_q.alarm;
  assign res.entry_mode     = res_q.entry_mode;
  assign res.entered_count  = res_q.entered_count;
  assign res.first_use_flag = res_q.first_use_flag;

  // checks
  `KCL_ASSERT(a_alarm_on_wrong, res.valid && res.alarm |-> res.status == ST_WRONG, "alarm without wrong code")
  `KCL_ASSERT(a_idle_empty, res.valid && res.entry_mode == MD_IDLE |-> res.entered_count == 3'd0, "idle with digits held")
  `KCL_ASSERT(a_hold_input, key_q_valid && !advance |=> key_q_valid && $stable(key_q), "input request lost while stalled")
  `KCL_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid && !key_q_valid, "registers not empty after reset")

endmodule

// ===== hw/rtl/kcl_core.sv =====
// lock state and the one-request step function
// depends on kcl_pkg
module kcl_core
  import kcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  key_t      key,
  input  logic [3:0] max_fail,
  output lock_res_t res
);

  logic [3:0]       stored_code [CODE_LENGTH];
  logic [3:0]       entry_digits [CODE_LENGTH];
  logic [CNT_W-1:0] entry_count, entry_count_next;
  mode_t            mode_reg, mode_reg_next;
  logic             code_unset, code_unset_next;
  logic [3:0]       fail_count, fail_count_next;
  logic             relay, relay_next;

  status_t          status;
  logic             alarm;
  logic             dig_we;
  logic [IDX_W-1:0] wr_idx;
  logic             code_set;
  logic             match;
  logic [4:0]       fail_inc;
  logic             digit_ok;
  logic             room;

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      if (stored_code[k] != entry_digits[k]) match = 1'b0;
    end
  end

  assign digit_ok = (key.digit <= MAX_DIGIT);
  assign room     = (entry_count < CNT_W'(CODE_LENGTH));
  assign fail_inc = {1'b0, fail_count} + 5'd1;

  always_comb begin
    entry_count_next = entry_count;
    mode_reg_next    = mode_reg;
    code_unset_next  = code_unset;
    fail_count_next  = fail_count;
    relay_next       = relay;
    status           = ST_IGNORED;
    alarm            = 1'b0;
    dig_we           = 1'b0;
    code_set         = 1'b0;
    wr_idx           = entry_count[IDX_W-1:0];
    if (mode_reg == MD_IDLE) begin
      unique case (key.func)
        FN_DIGIT: begin
          if (digit_ok) begin
            dig_we           = 1'b1;
            wr_idx           = '0;
            entry_count_next = CNT_W'(1);
            mode_reg_next    = MD_READ;
            status           = ST_DIGIT;
          end
        end
        FN_CLOSE: begin
          relay_next = 1'b0;
          status     = ST_CLOSED;
        end
        FN_MENU: begin
          fail_count_next = '0;
          status          = ST_MENU;
        end
        FN_CHANGE: begin
          entry_count_next = '0;
          mode_reg_next    = MD_CHANGE;
          status           = ST_NONE;
        end
        FN_MATCH: begin
          relay_next = 1'b1;
          status     = ST_FINGER_OPEN;
        end
        FN_MISS: status = ST_FINGER_MISS;
        default: status = ST_IGNORED;
      endcase
    end else begin
      case (key.func)
        FN_DIGIT: begin
          if (digit_ok && room) begin
            dig_we           = 1'b1;
            entry_count_next = entry_count + CNT_W'(1);
            status           = ST_DIGIT;
          end
        end
        FN_CONFIRM: begin
          if (room) begin
            status = ST_FORMAT_ERR;
          end else begin
            if (mode_reg == MD_CHANGE) begin
              code_set        = 1'b1;
              code_unset_next = 1'b0;
              status          = ST_CODE_SET;
            end else if (match) begin
              relay_next = 1'b1;
              status     = ST_CORRECT;
            end else begin
              // wrong code: alarm once the limit is reached, then restart count
              if (fail_inc >= {1'b0, max_fail}) begin
                alarm           = 1'b1;
                fail_count_next = '0;
              end else begin
                fail_count_next = fail_inc[3:0];
              end
              status = ST_WRONG;
            end
            mode_reg_next    = MD_IDLE;
            entry_count_next = '0;
          end
        end
        FN_CANCEL: begin
          if (entry_count != '0) begin
            entry_count_next = entry_count - CNT_W'(1);
            status           = ST_CANCELLED;
          end else if (code_unset) begin
            status = ST_IGNORED;
          end else begin
            mode_reg_next = MD_IDLE;
            status        = ST_CANCELLED;
          end
        end
        default: status = ST_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      mode_reg    <= MD_CHANGE;
      code_unset  <= 1'b1;
      fail_count  <= '0;
      relay       <= 1'b0;
      for (int k = 0; k < CODE_LENGTH; k++) stored_code[k] <= '0;
    end else if (step) begin
      entry_count <= entry_count_next;
      mode_reg    <= mode_reg_next;
      code_unset  <= code_unset_next;
      fail_count  <= fail_count_next;
      relay       <= relay_next;
      if (code_set) begin
        for (int k = 0; k < CODE_LENGTH; k++) stored_code[k] <= entry_digits[k];
      end
    end
  end

  // entry buffer holds nothing meaningful until written
  always_ff @(posedge clk) begin
    if (step && dig_we) entry_digits[wr_idx] <= key.digit;
  end

  always_comb begin
    res.status         = status;
    res.door_open      = relay_next;
    res.alarm          = alarm;
    res.entry_mode     = mode_reg_next;
    res.entered_count  = 3'(entry_count_next);
    res.first_use_flag = code_unset_next;
  end

endmodule

// ===== verif/keypad_code_lock_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for keypad_code_lock: keypad and fingerprint events in,
// one lock result per event out, checked against a built-in behavioral predictor
// depends on kcl_pkg, kcl_key_if, kcl_res_if, kcl_cfg_if and keypad_code_lock
module keypad_code_lock_tb;
  import kcl_pkg::*;

  // longest run of cycles with no handshake on any channel before giving up
  localparam int QUIET_LIMIT = 2000;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;

  kcl_key_if key_bus ();
  kcl_res_if res_bus ();
  kcl_cfg_if cfg_bus ();

  keypad_code_lock u_dut (
    .clk (clk),
    .rst (rst),
    .key (key_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // lock predictor state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  logic [CODE_LENGTH-1:0][3:0] code_mem = '0;   // stored code, all zero digits
  logic [CODE_LENGTH-1:0][3:0] key_buf  = '0;   // digits typed so far
  int                          key_cnt  = 0;
  mode_t                       lock_mode = MD_CHANGE;  // first use opens a change entry
  logic                        no_code_yet = 1'b1;
  logic [3:0]                  miss_run = '0;   // wrong codes since the last alarm or menu event
  logic                        door_relay = 1'b0;
  logic [3:0]                  alarm_limit = MAX_FAIL_RESET;

  lock_res_t pending_results [$];

  int errors      = 0;
  int taken_items = 0;   // requests that did something other than get ignored
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;     // long receiver hold-off, counted down below
  int hold_asks = 0;     // hold-offs requested by the tests
  int hold_done = 0;     // hold-offs started by the counter
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // predictor: applies one key or sensor event, returns the result it causes
  // ---------------------------------------------------------------------------
  function automatic lock_res_t apply_key(func_t f, logic [3:0] d);
    lock_res_t  r;
    logic [4:0] next_miss;
    r.status = ST_IGNORED;
    r.alarm  = 1'b0;
    if (lock_mode == MD_IDLE) begin
      // only a valid digit starts a read entry; idle-only events act here
      case (f)
        FN_DIGIT: if (d <= MAX_DIGIT) begin
          key_buf[0] = d;
          key_cnt    = 1;
          lock_mode  = MD_READ;
          r.status   = ST_DIGIT;
        end
        FN_CLOSE: begin
          door_relay = 1'b0;
          r.status   = ST_CLOSED;
        end
        FN_MENU: begin
          miss_run = '0;
          r.status = ST_MENU;
        end
        FN_CHANGE: begin
          key_cnt   = 0;
          lock_mode = MD_CHANGE;
          r.status  = ST_NONE;
        end
        FN_MATCH: begin
          door_relay = 1'b1;
          r.status   = ST_FINGER_OPEN;
        end
        FN_MISS: r.status = ST_FINGER_MISS;
        default: ;
      endcase
    end else if (f == FN_DIGIT) begin
      // digits past a full entry and keys above nine are dropped
      if (d <= MAX_DIGIT && key_cnt < CODE_LENGTH) begin
        key_buf[key_cnt] = d;
        key_cnt++;
        r.status = ST_DIGIT;
      end
    end else if (f == FN_CONFIRM) begin
      if (key_cnt < CODE_LENGTH) begin
        r.status = ST_FORMAT_ERR;   // short entry, stays open
      end else begin
        if (lock_mode == MD_CHANGE) begin
          code_mem    = key_buf;
          no_code_yet = 1'b0;
          r.status    = ST_CODE_SET;
        end else if (key_buf == code_mem) begin
          door_relay = 1'b1;
          r.status   = ST_CORRECT;
        end else begin
          // alarm when the new count reaches the limit, a limit of zero always fires
          next_miss = {1'b0, miss_run} + 5'd1;
          if (next_miss >= {1'b0, alarm_limit}) begin
            r.alarm  = 1'b1;
            miss_run = '0;
          end else begin
            miss_run = next_miss[3:0];
          end
          r.status = ST_WRONG;
        end
        lock_mode = MD_IDLE;
        key_cnt   = 0;
      end
    end else if (f == FN_CANCEL) begin
      // backspace, or leave an empty entry unless no code exists yet
      if (key_cnt > 0) begin
        key_cnt--;
        r.status = ST_CANCELLED;
      end else if (!no_code_yet) begin
        lock_mode = MD_IDLE;
        r.status  = ST_CANCELLED;
      end
    end
    // close, menu, change and finger events during an entry fall through as ignored
    r.door_open      = door_relay;
    r.entry_mode     = lock_mode;
    r.entered_count  = 3'(key_cnt);
    r.first_use_flag = no_code_yet;
    return r;
  endfunction

  function automatic logic [3:0] any_nibble();
    return 4'($urandom_range(15));
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random ready, long hold-off, compare against oldest prediction
  // ---------------------------------------------------------------------------
  task automatic flag_field(string name, logic [3:0] want, logic [3:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
  endtask

  task automatic check_result();
    lock_res_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t ns: result with no request pending, expected none actual status %0d",
               $time, res_bus.status);
    end else begin
      want = pending_results.pop_front();
      if (res_bus.status !== want.status)
        flag_field("status", want.status, res_bus.status);
      if (res_bus.door_open !== want.door_open)
        flag_field("door_open", want.door_open, res_bus.door_open);
      if (res_bus.alarm !== want.alarm)
        flag_field("alarm", want.alarm, res_bus.alarm);
      if (res_bus.entry_mode !== want.entry_mode)
        flag_field("entry_mode", want.entry_mode, res_bus.entry_mode);
      if (res_bus.entered_count !== want.entered_count)
        flag_field("entered_count", want.entered_count, res_bus.entered_count);
      if (res_bus.first_use_flag !== want.first_use_flag)
        flag_field("first_use_flag", want.first_use_flag, res_bus.first_use_flag);
    end
  endtask

  // hold-off counter lives in its own process
  always @(posedge clk) begin
    if (hold_asks != hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asks;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // all values read here are the ones from before the edge
  always @(posedge clk) begin
    res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    if (!rst && res_bus.valid && res_bus.ready) check_result();
  end

  // watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if ((key_bus.valid && key_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // valid stays high after acceptance; whoever stops sending lowers it
  task automatic push_key(func_t f, logic [3:0] d);
    lock_res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      key_bus.valid <= 1'b0;
      @(posedge clk);
    end
    key_bus.valid <= 1'b1;
    key_bus.func  <= f;
    key_bus.digit <= d;
    @(posedge clk);
    while (!key_bus.ready) @(posedge clk);
    want = apply_key(f, d);
    pending_results.push_back(want);
    if (want.status != ST_IGNORED) taken_items++;
  endtask

  // sender pauses until every result is back
  task automatic wait_drained();
    key_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // drains every pending result first, so no request is in flight during the write
  task automatic write_max_fail(logic [3:0] v);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    alarm_limit = v;
  endtask

  // full six-digit entry then confirm
  // pick 0: sure-wrong code, 1: stored code, 2: coin flip, may open a change entry
  task automatic run_code_entry(int pick);
    logic right;
    logic [3:0] wrong0;
    if (pick == 2 && lock_mode == MD_IDLE && $urandom_range(7) == 0)
      push_key(FN_CHANGE, any_nibble());
    right = (pick == 1) || (pick == 2 && $urandom_range(1) == 1);
    while (key_cnt < CODE_LENGTH) begin
      wrong0 = (code_mem[0] == 4'd9) ? 4'd0 : code_mem[0] + 4'd1;
      if (key_cnt > 0 && $urandom_range(11) == 0)
        push_key(FN_CANCEL, any_nibble());
      else if (right)
        push_key(FN_DIGIT, code_mem[key_cnt]);
      else if (pick == 0 && key_cnt == 0)
        push_key(FN_DIGIT, wrong0);
      else
        push_key(FN_DIGIT, 4'($urandom_range(9)));
    end
    push_key(FN_CONFIRM, any_nibble());
  endtask

  // short entry that ends in a format error or is cancelled away
  task automatic run_broken_entry();
    int target;
    target = $urandom_range(1, CODE_LENGTH - 1);
    if (lock_mode == MD_IDLE && $urandom_range(3) == 0) push_key(FN_CHANGE, any_nibble());
    while (key_cnt < target) push_key(FN_DIGIT, 4'($urandom_range(9)));
    if ($urandom_range(1) == 1) begin
      push_key(FN_CONFIRM, any_nibble());
    end else begin
      while (key_cnt > 0) push_key(FN_CANCEL, any_nibble());
      push_key(FN_CANCEL, any_nibble());
    end
  endtask

  // any event with any key value, digits above nine included
  task automatic run_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) push_key(func_t'(3'($urandom_range(7))), any_nibble());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // first use: empty cancel held, short confirm, bad key, full entry, backspace
  task automatic test_first_use();
    push_key(FN_CANCEL, 4'd0);
    push_key(FN_CONFIRM, 4'd0);
    push_key(FN_DIGIT, 4'd15);
    push_key(FN_DIGIT, 4'd9);
    push_key(FN_DIGIT, 4'd8);
    push_key(FN_DIGIT, 4'd1);
    push_key(FN_DIGIT, 4'd2);
    push_key(FN_DIGIT, 4'd4);
    push_key(FN_DIGIT, 4'd7);
    push_key(FN_DIGIT, 4'd3);     // entry already full
    push_key(FN_CANCEL, 4'd0);
    push_key(FN_DIGIT, 4'd0);
    push_key(FN_CONFIRM, 4'd0);   // code 9 8 1 2 4 0 stored
  endtask

  // every idle-only event, then an empty change entry left by cancel
  task automatic test_idle_events();
    push_key(FN_CONFIRM, 4'd0);
    push_key(FN_CANCEL, 4'd0);
    push_key(FN_MATCH, 4'd0);
    push_key(FN_CLOSE, 4'd0);
    push_key(FN_MISS, 4'd0);
    push_key(FN_MENU, 4'd0);
    push_key(FN_CHANGE, 4'd0);
    push_key(FN_CANCEL, 4'd0);
  endtask

  // idle-only events are ignored inside a read entry, then the right code opens
  task automatic test_entry_events();
    push_key(FN_DIGIT, 4'd9);
    push_key(FN_CLOSE, 4'd15);
    push_key(FN_MENU, 4'd0);
    push_key(FN_CHANGE, 4'd0);
    push_key(FN_MATCH, 4'd0);
    push_key(FN_MISS, 4'd0);
    push_key(FN_DIGIT, 4'd8);
    push_key(FN_DIGIT, 4'd1);
    push_key(FN_DIGIT, 4'd2);
    push_key(FN_DIGIT, 4'd4);
    push_key(FN_DIGIT, 4'd0);
    push_key(FN_CONFIRM, 4'd0);
  endtask

  // enough wrong codes at the limit extremes to fire the alarm and restart the count
  task automatic test_fail_limits();
    logic [3:0] limits [3];
    int tries;
    limits = '{4'd1, 4'd15, 4'd0};
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    foreach (limits[i]) begin
      write_max_fail(limits[i]);
      tries = (limits[i] == 4'd0) ? 2 : int'(limits[i]) + 1;
      repeat (tries) run_code_entry(0);
    end
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (hold_left != 0) @(posedge clk);
    hold_asks <= hold_asks + 1;
    repeat (24) push_key(func_t'(3'($urandom_range(7))), any_nibble());
    wait_drained();
  endtask

  // mostly well-formed entries with random content, some noise and broken entries
  task automatic test_random_traffic();
    logic [3:0] limits [4];
    int send_tab [4];
    int recv_tab [4];
    int stop_at;
    int kind;
    limits   = '{4'd1, 4'd15, 4'd5, 4'd3};
    send_tab = '{0, 63, 0, 10};
    recv_tab = '{0, 0, 63, 10};
    for (int p = 0; p < 4; p++) begin
      write_max_fail((p == 2) ? 4'($urandom_range(2, 14)) : limits[p]);
      send_idle_pct  = send_tab[p];
      recv_stall_pct = recv_tab[p];
      stop_at = taken_items + 165;
      while (taken_items < stop_at) begin
        kind = $urandom_range(99);
        if (kind < 60) run_code_entry(2);
        else if (kind < 85) run_noise();
        else run_broken_entry();
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    key_bus.valid <= 1'b0;
    key_bus.func  <= FN_DIGIT;
    key_bus.digit <= 4'd0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= MAX_FAIL_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_first_use();
    test_idle_events();
    test_entry_events();
    test_fail_limits();
    test_backpressure();
    test_random_traffic();

    // let any stray result show up before the verdict
    wait_drained();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_key_if.sv
hw/rtl/kcl_res_if.sv
hw/rtl/kcl_cfg_if.sv
hw/rtl/kcl_core.sv
hw/rtl/keypad_code_lock.sv
verif/keypad_code_lock_tb.sv
